/* rtl/radix_to_ascii_converter_top_defines.svh */
// Assertion macros for the radix-to-ASCII converter checker.
// Used by r2a_checker.sv; expects clk and rst_n in scope.
`ifndef RADIX_TO_ASCII_CONVERTER_TOP_DEFINES_SVH
`define RADIX_TO_ASCII_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define R2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define R2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/r2a_pkg.sv */
// Shared types, constants and helper functions for the radix-to-ASCII converter.
// No dependencies.
`default_nettype none

package r2a_pkg;

    localparam int INTEGER_BITS_DEF        = 32;
    localparam int FRACTION_BITS_DEF       = 32;
    localparam int MAX_FRACTION_DIGITS_DEF = 16;

    localparam int RADIX_W       = 6;
    localparam int DIGIT_W       = 6;
    localparam int CHAR_W        = 8;
    localparam int DIV_BITS      = 8;   // quotient bits resolved per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 6'd9;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET = 8'd55;  // 10 -> 'A'

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_int;
        logic emit_dot;
        logic emit_frac;
    } r2a_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic count_full;
        logic idx_zero;
        logic frac_zero;
        logic frac_done;
        logic out_free;
    } r2a_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        return (d > DIGIT_NINE) ? dx + ALPHA_OFFSET : dx + ASCII_ZERO;
    endfunction

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        else
            res = r;
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/r2a_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module r2a_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/r2a_datapath.sv */
// Datapath: radix register, digit-serial divider, fraction multiplier,
// digit store and output register. Depends on r2a_pkg and r2a_ram.
`default_nettype none

module r2a_datapath #(
    parameter int INTEGER_BITS        = r2a_pkg::INTEGER_BITS_DEF,
    parameter int FRACTION_BITS       = r2a_pkg::FRACTION_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = r2a_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              radix_we,
    input  wire logic [r2a_pkg::RADIX_W-1:0]       radix_wdata,
    input  wire logic [INTEGER_BITS-1:0]           integer_part,
    input  wire logic [FRACTION_BITS-1:0]          fraction_part,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [r2a_pkg::CHAR_W-1:0]        ascii_char,
    output logic                                   last_char,
    input  wire r2a_pkg::r2a_cmd_t                 cmd,
    output r2a_pkg::r2a_sts_t                      sts
);

    import r2a_pkg::*;

    localparam int STEPS = (INTEGER_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int WW    = STEPS * DIV_BITS;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CW    = $clog2(INTEGER_BITS + 1);
    localparam int AW    = $clog2(INTEGER_BITS);
    localparam int FCW   = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int PW    = FRACTION_BITS + RADIX_W;

    logic [RADIX_W-1:0]       radix_reg;
    logic [RADIX_W-1:0]       r_eff;
    logic [WW-1:0]            work_reg;
    logic [WW-1:0]            work_shift;
    logic [DIGIT_W-1:0]       rem_reg;
    logic [DIGIT_W-1:0]       rem_next;
    logic [DIV_BITS-1:0]      qbits;
    logic [SW-1:0]            step_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            idx_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [FCW-1:0]           fcnt_reg;
    logic [PW-1:0]            prod;
    logic [DIGIT_W-1:0]       frac_digit;
    logic [FRACTION_BITS-1:0] frac_rest;
    logic [DIGIT_W-1:0]       rd_digit;
    logic                     ram_we;
    logic                     out_valid_reg;
    logic [CHAR_W-1:0]        char_reg;
    logic                     last_reg;
    logic                     emit;

    assign r_eff = sat_radix(radix_reg);

    // Restoring division, DIV_BITS quotient bits per cycle, MSB first.
    always_comb
    begin
        logic [DIV_BITS-1:0]  top;
        logic [DIGIT_W:0]     trial;
        logic [DIGIT_W-1:0]   rem;
        top   = work_reg[WW-1 -: DIV_BITS];
        rem   = rem_reg;
        qbits = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            trial = {rem, top[i]};
            if (trial >= {1'b0, r_eff})
            begin
                rem      = DIGIT_W'(trial - {1'b0, r_eff});
                qbits[i] = 1'b1;
            end
            else
            begin
                rem = DIGIT_W'(trial);
            end
        end
        rem_next   = rem;
        work_shift = (work_reg << DIV_BITS) | WW'(qbits);
    end

    // Fraction step: digit above the binary point, rest below.
    assign prod       = PW'(frac_reg) * PW'(r_eff);
    assign frac_digit = prod[PW-1 -: DIGIT_W];
    assign frac_rest  = prod[FRACTION_BITS-1:0];

    assign ram_we = cmd.div_step && sts.div_last;

    r2a_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (INTEGER_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rem_next),
        .raddr (idx_reg),
        .rdata (rd_digit)
    );

    assign emit = cmd.emit_int || cmd.emit_dot || cmd.emit_frac;

    always_comb
    begin
        sts.div_last   = (step_reg == SW'(STEPS - 1));
        sts.quot_zero  = (work_shift == '0);
        sts.count_full = (count_reg == CW'(INTEGER_BITS - 1));
        sts.idx_zero   = (idx_reg == '0);
        sts.frac_zero  = (frac_reg == '0);
        sts.frac_done  = (frac_rest == '0) || (fcnt_reg == FCW'(MAX_FRACTION_DIGITS - 1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            step_reg      <= '0;
            count_reg     <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
            if (cmd.load)
            begin
                step_reg  <= '0;
                count_reg <= '0;
                fcnt_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= sts.div_last ? '0 : SW'(step_reg + 1'b1);
                if (sts.div_last)
                begin
                    count_reg <= CW'(count_reg + 1'b1);
                end
            end
            if (cmd.emit_frac)
            begin
                fcnt_reg <= FCW'(fcnt_reg + 1'b1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= WW'(integer_part);
            frac_reg <= fraction_part;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_shift;
            rem_reg  <= sts.div_last ? '0 : rem_next;
            if (sts.div_last)
            begin
                idx_reg <= count_reg[AW-1:0];
            end
        end
        if (cmd.emit_int)
        begin
            idx_reg  <= AW'(idx_reg - 1'b1);
            char_reg <= digit_char(rd_digit);
            last_reg <= sts.idx_zero && sts.frac_zero;
        end
        else if (cmd.emit_dot)
        begin
            char_reg <= ASCII_DOT;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_frac)
        begin
            frac_reg <= frac_rest;
            char_reg <= digit_char(frac_digit);
            last_reg <= sts.frac_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule

`default_nettype wire

/* rtl/r2a_ctrl.sv */
// Sequencer: divide, read back digits MSB first, dot, fraction digits.
// Depends on r2a_pkg.
`default_nettype none

module r2a_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire r2a_pkg::r2a_sts_t   sts,
    output r2a_pkg::r2a_cmd_t        cmd
);

    import r2a_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_INT  = 6'b001000,
        ST_DOT  = 6'b010000,
        ST_FRAC = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last && (sts.quot_zero || sts.count_full))
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // digit store read latency
                state_next = ST_INT;
            end
            ST_INT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_int = 1'b1;
                    if (!sts.idx_zero)
                        state_next = ST_RD;
                    else if (sts.frac_zero)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_dot = 1'b1;
                    state_next   = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_frac = 1'b1;
                    if (sts.frac_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/radix_to_ascii_converter_top.sv */
// Radix-to-ASCII converter top level: controller plus datapath.
// Depends on r2a_pkg, r2a_ctrl, r2a_datapath (and r2a_ram below it).
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one unsigned fixed-point number
//    per transaction: integer_part and fraction_part (Q0.FRACTION_BITS).
//  - Output channel (out_valid/out_ready) returns its spelling one character
//    per transaction, MSB digit first, then '.' and fraction digits when the
//    fraction is nonzero; last_char marks the final character.
//  - radix_we/radix_wdata writes the base (saturated to 2..36); write it only
//    while no number is in flight.
//  - Steps for a number: accept, then divider steps for each integer digit
//    (the divider resolves 8 quotient bits per cycle), then a digit store
//    read and an emit per integer character, then '.' and one emit per
//    fraction digit when the fraction is nonzero. The worst case is radix 2
//    with 32 integer and 16 fraction digits.
//  - One number at a time; in_ready rises once the last character is in the
//    output register, so the next number starts while it waits to be taken.
//  - A stalled receiver holds the output register; the sequencer waits.
//  - Reset empties the output register, returns to idle, sets radix to 10.
`default_nettype none

module radix_to_ascii_converter_top #(
    parameter int INTEGER_BITS        = r2a_pkg::INTEGER_BITS_DEF,
    parameter int FRACTION_BITS       = r2a_pkg::FRACTION_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = r2a_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          radix_we,
    input  wire logic [r2a_pkg::RADIX_W-1:0]   radix_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [INTEGER_BITS-1:0]       integer_part,
    input  wire logic [FRACTION_BITS-1:0]      fraction_part,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [r2a_pkg::CHAR_W-1:0]    ascii_char,
    output logic                               last_char
);

    import r2a_pkg::*;

    r2a_cmd_t cmd;
    r2a_sts_t sts;

    // Sequencer
    r2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic, digit store and output register
    r2a_datapath #(
        .INTEGER_BITS        (INTEGER_BITS),
        .FRACTION_BITS       (FRACTION_BITS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix_we      (radix_we),
        .radix_wdata   (radix_wdata),
        .integer_part  (integer_part),
        .fraction_part (fraction_part),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .ascii_char    (ascii_char),
        .last_char     (last_char),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

/* rtl/r2a_checker.sv */
// Port-level checker for the radix-to-ASCII converter, bound to the top.
// Depends on r2a_pkg and radix_to_ascii_converter_top_defines.svh.
`default_nettype none

`include "radix_to_ascii_converter_top_defines.svh"

module r2a_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [r2a_pkg::CHAR_W-1:0]  ascii_char,
    input wire logic                        last_char
);

    import r2a_pkg::*;

    // only digits, capitals and the dot leave the block
    `R2A_ASSERT_NOW(a_char_legal, out_valid, ((ascii_char >= ASCII_ZERO) && (ascii_char <= ASCII_NINE)) || ((ascii_char >= ASCII_UPPER_A) && (ascii_char <= ASCII_UPPER_Z)) || (ascii_char == ASCII_DOT), "illegal character")

    // the dot is always followed by at least one fraction digit
    `R2A_ASSERT_NOW(a_dot_not_last, out_valid && (ascii_char == ASCII_DOT), !last_char, "dot flagged last")

    // one number at a time: no new input mid-spelling
    `R2A_ASSERT_NOW(a_busy_mid_number, out_valid && !last_char, !in_ready, "ready mid-number")

    // a stalled character holds
    `R2A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ascii_char) && $stable(last_char), "output changed under stall")

endmodule

bind radix_to_ascii_converter_top r2a_checker u_r2a_checker (.*);

`default_nettype wire
